// File: sv/u2u8_pkg.sv
// Shared types, constants and encoding functions of the UTF-16 to UTF-8 converter.
package u2u8_pkg;

	localparam logic [5:0]  SUR_HIGH_TAG = 6'b110110;
	localparam logic [5:0]  SUR_LOW_TAG  = 6'b110111;
	localparam logic [15:0] RIGHT_QUOTE  = 16'h2019;
	localparam logic [7:0]  APOSTROPHE   = 8'h27;
	localparam logic [7:0]  QUOTE_B0     = 8'hE2;
	localparam logic [7:0]  QUOTE_B1     = 8'h80;
	localparam logic [7:0]  QUOTE_B2     = 8'h99;
	localparam logic [1:0]  CONT_TAG     = 2'b10;
	localparam logic [2:0]  LEAD2_TAG    = 3'b110;
	localparam logic [3:0]  LEAD3_TAG    = 4'b1110;
	localparam logic [4:0]  LEAD4_TAG    = 5'b11110;
	localparam logic [20:0] SUPPL_BASE   = 21'h010000;
	localparam int          MAX_BYTES    = 9;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_BMP,
		OP_PAIR,
		OP_TERM
	} u2u8_op_t;

	// Work for the back end: an optional quote prefix, an optional released
	// high surrogate and the main operation.
	typedef struct packed {
		logic       apos;
		logic       quote;
		logic       rel;
		u2u8_op_t   op;
		logic [9:0] hb;
		logic [15:0] unit;
	} u2u8_cmd_t;

	typedef struct packed {
		logic      valid;
		u2u8_cmd_t cmd;
	} u2u8_q_t;

	// Up to four bytes, first byte in the top bits.
	typedef struct packed {
		logic [31:0] bytes;
		logic [3:0]  len;
	} u2u8_seg_t;

	function automatic u2u8_seg_t enc_bmp(logic [15:0] u);
		u2u8_seg_t s;
		if (u < 16'h0080) begin
			s.bytes = {u[7:0], 24'h0};
			s.len = 4'd1;
		end else if (u < 16'h0800) begin
			s.bytes = {LEAD2_TAG, u[10:6], CONT_TAG, u[5:0], 16'h0};
			s.len = 4'd2;
		end else begin
			s.bytes = {LEAD3_TAG, u[15:12], CONT_TAG, u[11:6], CONT_TAG, u[5:0], 8'h0};
			s.len = 4'd3;
		end
		return s;
	endfunction

	function automatic u2u8_seg_t enc_pair(logic [9:0] hb, logic [15:0] lo);
		u2u8_seg_t s;
		logic [20:0] cp;
		cp = {1'b0, hb, lo[9:0]} + SUPPL_BASE;
		s.bytes = {LEAD4_TAG, cp[20:18], CONT_TAG, cp[17:12], CONT_TAG, cp[11:6],
			CONT_TAG, cp[5:0]};
		s.len = 4'd4;
		return s;
	endfunction

endpackage

// File: sv/u2u8_if.sv
// Valid/ready channel interfaces for code units in and bytes out.
interface u2u8_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;

	modport source (output valid, output code_unit, input ready);
	modport sink (input valid, input code_unit, output ready);
endinterface

interface u2u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       string_end;

	modport source (output valid, output out_byte, output last_of_run, output string_end,
		input ready);
	modport sink (input valid, input out_byte, input last_of_run, input string_end,
		output ready);
endinterface

// File: sv/u2u8_front.sv
// Front end: accepts code units, tracks surrogate and quote state, issues byte work.
module u2u8_front import u2u8_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	u2u8_in_if.sink         unit_ch,
	input  logic            q_ready,
	output u2u8_q_t         push
);

	logic [9:0] hb_q;
	logic       sur_pend_q;
	logic       at_start_q;
	logic       quote_held_q;

	logic [9:0] hb_d;
	logic       sur_pend_d;
	logic       at_start_d;
	logic       quote_held_d;
	logic       accept;
	logic       is_high;
	logic       is_low;
	u2u8_cmd_t  cmd;

	assign unit_ch.ready = q_ready;
	assign accept = unit_ch.valid && q_ready;
	assign is_high = (unit_ch.code_unit[15:10] == SUR_HIGH_TAG);
	assign is_low = (unit_ch.code_unit[15:10] == SUR_LOW_TAG);

	always_comb begin
		hb_d = hb_q;
		sur_pend_d = sur_pend_q;
		at_start_d = at_start_q;
		quote_held_d = quote_held_q;
		cmd.apos = 1'b0;
		cmd.quote = 1'b0;
		cmd.rel = 1'b0;
		cmd.op = OP_NONE;
		cmd.hb = hb_q;
		cmd.unit = unit_ch.code_unit;
		if (unit_ch.code_unit == 16'h0) begin
			cmd.apos = quote_held_q;
			cmd.op = OP_TERM;
			hb_d = '0;
			sur_pend_d = 1'b0;
			at_start_d = 1'b1;
			quote_held_d = 1'b0;
		end else if (quote_held_q && !sur_pend_q && is_high) begin
			// The quote stays held together with the new high surrogate.
			sur_pend_d = 1'b1;
			hb_d = unit_ch.code_unit[9:0];
		end else begin
			cmd.quote = quote_held_q;
			quote_held_d = 1'b0;
			at_start_d = 1'b0;
			sur_pend_d = 1'b0;
			if (sur_pend_q && is_low) begin
				cmd.op = OP_PAIR;
			end else begin
				cmd.rel = sur_pend_q;
				if (is_high) begin
					sur_pend_d = 1'b1;
					hb_d = unit_ch.code_unit[9:0];
				end else if (at_start_q && unit_ch.code_unit == RIGHT_QUOTE) begin
					quote_held_d = 1'b1;
				end else begin
					cmd.op = OP_BMP;
				end
			end
		end
	end

	assign push.cmd = cmd;
	assign push.valid = accept && (cmd.quote || cmd.rel || cmd.op != OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_q <= '0;
			sur_pend_q <= 1'b0;
			at_start_q <= 1'b1;
			quote_held_q <= 1'b0;
		end else if (accept) begin
			hb_q <= hb_d;
			sur_pend_q <= sur_pend_d;
			at_start_q <= at_start_d;
			quote_held_q <= quote_held_d;
		end
	end

endmodule

// File: sv/u2u8_queue.sv
// Small register queue of byte work between the front and back ends.
module u2u8_queue import u2u8_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  u2u8_q_t push,
	output logic    not_full,
	output u2u8_q_t head,
	input  logic    pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	u2u8_cmd_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign not_full = (count_q != CNT_W'(DEPTH));
	assign do_push = push.valid && not_full;
	assign do_pop = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/u2u8_back.sv
// Back end: expands queued work into bytes and sends one byte per cycle while the byte channel is ready.
module u2u8_back import u2u8_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  u2u8_q_t   head,
	output logic      pop,
	u2u8_out_if.source byte_ch
);

	localparam int BUF_W = 8 * MAX_BYTES;

	logic [BUF_W-1:0] buf_q;
	logic [3:0]       rem_q;
	logic             term_q;
	logic             ovalid_q;
	logic [7:0]       obyte_q;
	logic             olast_q;
	logic             oend_q;

	logic [BUF_W-1:0] list;
	logic [3:0]       n;
	u2u8_seg_t        pre;
	u2u8_seg_t        rel;
	u2u8_seg_t        main;
	logic             out_free;
	logic             move;

	// Lay the segments of one item side by side, first byte at the top.
	always_comb begin
		pre.bytes = '0;
		pre.len = 4'd0;
		if (head.cmd.apos) begin
			pre.bytes = {APOSTROPHE, 24'h0};
			pre.len = 4'd1;
		end else if (head.cmd.quote) begin
			pre.bytes = {QUOTE_B0, QUOTE_B1, QUOTE_B2, 8'h0};
			pre.len = 4'd3;
		end
		rel.bytes = '0;
		rel.len = 4'd0;
		if (head.cmd.rel) begin
			rel = enc_bmp({SUR_HIGH_TAG, head.cmd.hb});
		end
		case (head.cmd.op)
			OP_BMP:  main = enc_bmp(head.cmd.unit);
			OP_PAIR: main = enc_pair(head.cmd.hb, head.cmd.unit);
			OP_TERM: main = '{bytes: 32'h0, len: 4'd1};
			default: main = '{bytes: 32'h0, len: 4'd0};
		endcase
		list = {pre.bytes, 40'h0};
		n = pre.len;
		list = list | ({rel.bytes, 40'h0} >> {n, 3'b000});
		n = n + rel.len;
		list = list | ({main.bytes, 40'h0} >> {n, 3'b000});
		n = n + main.len;
	end

	assign out_free = !ovalid_q || byte_ch.ready;
	assign move = out_free && (rem_q != 4'd0);
	assign pop = head.valid && ((rem_q == 4'd0) || (rem_q == 4'd1 && move));

	assign byte_ch.valid = ovalid_q;
	assign byte_ch.out_byte = obyte_q;
	assign byte_ch.last_of_run = olast_q;
	assign byte_ch.string_end = oend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 4'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				rem_q <= n;
			end else if (move) begin
				rem_q <= rem_q - 4'd1;
			end
			if (move) begin
				ovalid_q <= 1'b1;
			end else if (out_free) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			buf_q <= list;
			term_q <= (head.cmd.op == OP_TERM);
		end else if (move) begin
			buf_q <= {buf_q[BUF_W-9:0], 8'h0};
		end
		if (move) begin
			obyte_q <= buf_q[BUF_W-1 -: 8];
			olast_q <= (rem_q == 4'd1);
			oend_q <= term_q && (rem_q == 4'd1);
		end
	end

endmodule

// File: sv/utf16_to_utf8_stream.sv
// Streaming UTF-16 to UTF-8 converter, one code unit in and one byte out per item.
// Each accepted unit's work passes through the queue, the byte buffer and then the output register.
// Throughput: the output register sends one byte per cycle while the byte channel is ready,
// and a unit yields 1 to 9 bytes for the byte sender (about 1 to 3 in practice).
// Units that only change state are taken by the front end and push no work to the back end.
// Reset clears the queue and output register and returns the state to a string start.
module utf16_to_utf8_stream import u2u8_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	u2u8_in_if.sink    unit_ch,
	u2u8_out_if.source byte_ch
);

	u2u8_q_t push;
	u2u8_q_t head;
	logic    q_ready;
	logic    pop;

	u2u8_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.unit_ch (unit_ch),
		.q_ready (q_ready),
		.push    (push)
	);

	u2u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.not_full (q_ready),
		.head     (head),
		.pop      (pop)
	);

	u2u8_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.byte_ch (byte_ch)
	);

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the UTF-16 to UTF-8 stream converter.
module tb_top import u2u8_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] HIGH_FIRST  = 16'hD800;
	localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST   = 16'hDC00;
	localparam logic [15:0] LOW_LAST    = 16'hDFFF;
	localparam logic [15:0] END_OF_TEXT = 16'h0000;
	localparam int          STALL_LIMIT = 1000;
	localparam int          TAIL_CYCLES = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       str_end;
	} utf8_byte_t;

	logic clk;
	logic arst_n;

	u2u8_in_if  unit_ch();
	u2u8_out_if byte_ch();

	utf16_to_utf8_stream i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.unit_ch (unit_ch),
		.byte_ch (byte_ch)
	);

	// Predicted converter state.
	logic [9:0] held_hi_bits;
	logic       hi_pending;
	logic       at_start;
	logic       quote_waiting;

	utf8_byte_t expected_bytes[$];
	utf8_byte_t run_bytes[$];
	int         errors;
	int         idle_cycles;
	bit         no_gaps;

	always #5 clk = ~clk;

	function automatic bit is_high(logic [15:0] u);
		return u >= HIGH_FIRST && u <= HIGH_LAST;
	endfunction

	function automatic bit is_low(logic [15:0] u);
		return u >= LOW_FIRST && u <= LOW_LAST;
	endfunction

	function void put_byte(logic [7:0] b, logic str_end);
		run_bytes.push_back(utf8_byte_t'{data: b, last: 1'b0, str_end: str_end});
	endfunction

	function void put_bmp_bytes(logic [15:0] u);
		if (u < 16'h0080) begin
			put_byte(u[7:0], 1'b0);
		end else if (u < 16'h0800) begin
			put_byte(8'(16'h00C0 | (u >> 6)), 1'b0);
			put_byte(8'(16'h0080 | (u & 16'h003F)), 1'b0);
		end else begin
			put_byte(8'(16'h00E0 | (u >> 12)), 1'b0);
			put_byte(8'(16'h0080 | ((u >> 6) & 16'h003F)), 1'b0);
			put_byte(8'(16'h0080 | (u & 16'h003F)), 1'b0);
		end
	endfunction

	function void put_pair_bytes(logic [9:0] hi_bits, logic [15:0] lo);
		logic [20:0] cp;
		cp = (21'(hi_bits) << 10) + 21'(lo - LOW_FIRST) + 21'h010000;
		put_byte(8'(21'h0000F0 | (cp >> 18)), 1'b0);
		put_byte(8'(21'h000080 | ((cp >> 12) & 21'h3F)), 1'b0);
		put_byte(8'(21'h000080 | ((cp >> 6) & 21'h3F)), 1'b0);
		put_byte(8'(21'h000080 | (cp & 21'h3F)), 1'b0);
	endfunction

	// Works out the bytes that one accepted code unit produces and queues them.
	function void predict_utf8(logic [15:0] u);
		bit joined;
		bit only_held;
		joined = 1'b0;
		only_held = 1'b0;
		run_bytes.delete();
		if (u == END_OF_TEXT) begin
			if (quote_waiting)
				put_byte(APOSTROPHE, 1'b0);
			put_byte(8'h00, 1'b1);
			held_hi_bits = '0;
			hi_pending = 1'b0;
			at_start = 1'b1;
			quote_waiting = 1'b0;
		end else begin
			// A leading quote keeps waiting across one high surrogate.
			if (quote_waiting && !hi_pending && is_high(u)) begin
				hi_pending = 1'b1;
				held_hi_bits = u[9:0];
				only_held = 1'b1;
			end else if (quote_waiting) begin
				put_byte(QUOTE_B0, 1'b0);
				put_byte(QUOTE_B1, 1'b0);
				put_byte(QUOTE_B2, 1'b0);
				quote_waiting = 1'b0;
			end
			if (!only_held) begin
				if (hi_pending) begin
					hi_pending = 1'b0;
					if (is_low(u)) begin
						put_pair_bytes(held_hi_bits, u);
						joined = 1'b1;
					end else begin
						put_bmp_bytes(HIGH_FIRST | 16'(held_hi_bits));
					end
				end
				if (!joined) begin
					if (is_high(u)) begin
						hi_pending = 1'b1;
						held_hi_bits = u[9:0];
					end else if (at_start && u == RIGHT_QUOTE) begin
						quote_waiting = 1'b1;
					end else begin
						put_bmp_bytes(u);
					end
				end
				at_start = 1'b0;
			end
		end
		if (run_bytes.size() > 0)
			run_bytes[run_bytes.size() - 1].last = 1'b1;
		foreach (run_bytes[i])
			expected_bytes.push_back(run_bytes[i]);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $realtime, what);
		errors++;
	endtask

	task automatic send_unit(input logic [15:0] u);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 26) begin
			unit_ch.valid = 1'b0;
			@(negedge clk);
		end
		unit_ch.valid = 1'b1;
		unit_ch.code_unit = u;
		@(posedge clk);
		while (!unit_ch.ready)
			@(posedge clk);
		predict_utf8(u);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		unit_ch.valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_unit();
		int kind;
		kind = $urandom_range(99);
		if (kind < 25)
			return 16'($urandom_range(1, 16'h007F));
		else if (kind < 40)
			return 16'($urandom_range(16'h0080, 16'h07FF));
		else if (kind < 55)
			return $urandom_range(1) ? 16'($urandom_range(16'h0800, 16'hD7FF)) :
				16'($urandom_range(16'hE000, 16'hFFFF));
		else if (kind < 60)
			return RIGHT_QUOTE;
		else if (kind < 72)
			return 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
		else if (kind < 80)
			return 16'($urandom_range(LOW_FIRST, LOW_LAST));
		else
			return 16'($urandom_range(1, 16'hFFFF));
	endfunction

	// Sends one string: mostly valid text and surrogate pairs, some broken
	// surrogates and stray quotes, closed by the terminator.
	task automatic send_random_string(inout int sent);
		int len;
		len = $urandom_range(0, 8);
		if ($urandom_range(4) == 0) begin
			send_unit(RIGHT_QUOTE);
			sent++;
		end
		repeat (len) begin
			if ($urandom_range(3) == 0) begin
				send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
				send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)));
				sent += 2;
			end else begin
				send_unit(pick_unit());
				sent++;
			end
		end
		send_unit(END_OF_TEXT);
		sent++;
	endtask

	task automatic test_encoding_widths();
		send_unit(END_OF_TEXT);
		send_unit(16'h0001);
		send_unit(16'h007F);
		send_unit(16'h0080);
		send_unit(16'h07FF);
		send_unit(16'h0800);
		send_unit(16'hFFFF);
		send_unit(END_OF_TEXT);
	endtask

	task automatic test_surrogates();
		send_unit(HIGH_FIRST);
		send_unit(LOW_FIRST);
		send_unit(HIGH_LAST);
		send_unit(LOW_LAST);
		send_unit(LOW_FIRST);
		send_unit(16'hD801);
		send_unit(16'h0041);
		send_unit(16'hD834);
		send_unit(END_OF_TEXT);
	endtask

	task automatic test_leading_quote();
		send_unit(RIGHT_QUOTE);
		send_unit(END_OF_TEXT);
		send_unit(RIGHT_QUOTE);
		send_unit(HIGH_FIRST);
		send_unit(END_OF_TEXT);
		send_unit(RIGHT_QUOTE);
		send_unit(16'h0041);
		send_unit(END_OF_TEXT);
	endtask

	task automatic test_random_strings(input int units);
		int sent;
		sent = 0;
		while (sent < units)
			send_random_string(sent);
	endtask

	task automatic test_back_to_back(input int units);
		no_gaps = 1'b1;
		test_random_strings(units);
		no_gaps = 1'b0;
	endtask

	task automatic test_drain_pauses(input int units);
		int sent;
		sent = 0;
		while (sent < units) begin
			send_random_string(sent);
			wait_drained();
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	always @(negedge clk)
		byte_ch.ready = no_gaps || ($urandom_range(99) >= 26);

	always @(posedge clk) begin
		utf8_byte_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("byte %02h arrived with none expected",
					byte_ch.out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (byte_ch.out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						byte_ch.out_byte, want.data));
				if (byte_ch.last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
						byte_ch.last_of_run, want.last, want.data));
				if (byte_ch.string_end !== want.str_end)
					report_mismatch($sformatf("string_end %b, expected %b on byte %02h",
						byte_ch.string_end, want.str_end, want.data));
			end
		end
	end

	// Ends the run when neither channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (unit_ch.valid && unit_ch.ready) || (byte_ch.valid && byte_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		unit_ch.valid = 1'b0;
		unit_ch.code_unit = '0;
		byte_ch.ready = 1'b0;
		errors = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		held_hi_bits = '0;
		hi_pending = 1'b0;
		at_start = 1'b1;
		quote_waiting = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_encoding_widths();
		test_surrogates();
		test_leading_quote();
		test_random_strings(110);
		test_back_to_back(60);
		test_drain_pauses(20);
		test_random_strings(55);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
sv/u2u8_pkg.sv
sv/u2u8_if.sv
sv/u2u8_front.sv
sv/u2u8_queue.sv
sv/u2u8_back.sv
sv/utf16_to_utf8_stream.sv
dv/tb_top.sv
